// ===== design/cal_pkg.sv =====
// Shared types and constants for the CoDel admission limiter.
`default_nettype none

package cal_pkg;

   // Field widths.
   localparam int TIME_W  = 48;
   localparam int DELAY_W = 24;
   localparam int TOKEN_W = 16;
   localparam int INDEX_W = 3;
   localparam int WDATA_W = 24;

   // Register values after reset.
   localparam logic [DELAY_W-1:0] DELAY_THRESHOLD_RESET = 24'd1000;
   localparam logic [DELAY_W-1:0] DISCARD_TIMEOUT_RESET = 24'd1500;
   localparam logic [DELAY_W-1:0] INTERVAL_RESET        = 24'd2000;
   localparam logic [TOKEN_W-1:0] TOKENS_PER_PERIOD_RESET = 16'd300;
   localparam logic [DELAY_W-1:0] TOKEN_PERIOD_RESET    = 24'd1000000;

   // Configuration register indexes.
   typedef enum logic [INDEX_W-1:0] {
      CSR_DELAY_THRESHOLD   = 3'd0,
      CSR_DISCARD_TIMEOUT   = 3'd1,
      CSR_INTERVAL          = 3'd2,
      CSR_TOKENS_PER_PERIOD = 3'd3,
      CSR_TOKEN_PERIOD      = 3'd4
   } csr_index_type;

   // Current configuration as seen by the decision logic.
   typedef struct packed {
      logic [DELAY_W-1:0] overload_limit_us;
      logic [DELAY_W-1:0] shed_delay_us;
      logic [DELAY_W-1:0] window_us;
      logic [TOKEN_W-1:0] tokens_per_period;
      logic [DELAY_W-1:0] token_period_us;
   } cfg_type;

endpackage

`default_nettype wire

// ===== design/cal_csr.sv =====
// Configuration registers of the admission limiter.
`default_nettype none

module cal_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [cal_pkg::INDEX_W-1:0]  csr_index,
   input  wire logic [cal_pkg::WDATA_W-1:0]  csr_wdata,
   output cal_pkg::cfg_type                  cfg
);

   cal_pkg::cfg_type cfg_ff;
   cal_pkg::cfg_type cfg_in;
   logic             write_en;

   // Writes are always taken.
   assign csr_ready = 1'b1;
   assign write_en  = csr_valid & csr_ready;

   // Decode the index; an unknown index leaves every register alone.
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (csr_index)
            cal_pkg::CSR_DELAY_THRESHOLD: begin
               cfg_in.overload_limit_us = csr_wdata;
            end
            cal_pkg::CSR_DISCARD_TIMEOUT: begin
               cfg_in.shed_delay_us = csr_wdata;
            end
            cal_pkg::CSR_INTERVAL: begin
               cfg_in.window_us = csr_wdata;
            end
            cal_pkg::CSR_TOKENS_PER_PERIOD: begin
               cfg_in.tokens_per_period = csr_wdata[cal_pkg::TOKEN_W-1:0];
            end
            cal_pkg::CSR_TOKEN_PERIOD: begin
               cfg_in.token_period_us = csr_wdata;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   // Register bank with its reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.overload_limit_us <= cal_pkg::DELAY_THRESHOLD_RESET;
         cfg_ff.shed_delay_us     <= cal_pkg::DISCARD_TIMEOUT_RESET;
         cfg_ff.window_us         <= cal_pkg::INTERVAL_RESET;
         cfg_ff.tokens_per_period <= cal_pkg::TOKENS_PER_PERIOD_RESET;
         cfg_ff.token_period_us   <= cal_pkg::TOKEN_PERIOD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== design/cal_step.sv =====
// Limiter state and the per-item admission decision.
`default_nettype none

module cal_step (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire cal_pkg::cfg_type             cfg,
   input  wire logic                         step_en,
   input  wire logic [cal_pkg::TIME_W-1:0]   now_us,
   input  wire logic [cal_pkg::DELAY_W-1:0]  queue_delay_us,
   output logic                              accept,
   output logic                              overloaded
);

   logic [cal_pkg::TOKEN_W-1:0] token_count_ff,     token_count_in;
   logic [cal_pkg::TIME_W-1:0]  token_deadline_ff,  token_deadline_in;
   logic [cal_pkg::DELAY_W-1:0] min_delay_ff,       min_delay_in;
   logic [cal_pkg::TIME_W-1:0]  window_deadline_ff, window_deadline_in;
   logic                        overload_flag_ff,   overload_flag_in;

   logic                        token_pass;
   logic                        window_pass;
   logic                        needs_token;
   logic [cal_pkg::TOKEN_W-1:0] refilled_count;

   // Deadline tests are strict; each advances by one period with wrap.
   assign token_pass  = now_us > token_deadline_ff;
   assign window_pass = now_us > window_deadline_ff;

   assign token_deadline_in = token_pass
      ? token_deadline_ff + {{(cal_pkg::TIME_W-cal_pkg::DELAY_W){1'b0}}, cfg.token_period_us}
      : token_deadline_ff;
   assign window_deadline_in = window_pass
      ? window_deadline_ff + {{(cal_pkg::TIME_W-cal_pkg::DELAY_W){1'b0}}, cfg.window_us}
      : window_deadline_ff;
   assign refilled_count = token_pass ? cfg.tokens_per_period : token_count_ff;

   // A late item, or a slow one while overloaded, has to spend a token.
   assign needs_token = (overload_flag_ff && (queue_delay_us > cfg.shed_delay_us))
                        || (queue_delay_us > cfg.window_us);

   // Window close or in-window update of minimum, flag and tokens.
   always_comb begin
      accept           = 1'b1;
      token_count_in   = refilled_count;
      overload_flag_in = overload_flag_ff;
      min_delay_in     = min_delay_ff;
      if (window_pass) begin
         overload_flag_in = min_delay_ff > cfg.overload_limit_us;
         min_delay_in     = queue_delay_us;
      end else begin
         if (queue_delay_us < min_delay_ff) begin
            min_delay_in = queue_delay_us;
         end
         if (needs_token) begin
            if (refilled_count == '0) begin
               accept = 1'b0;
            end else begin
               token_count_in = refilled_count - {{(cal_pkg::TOKEN_W-1){1'b0}}, 1'b1};
            end
         end
      end
   end

   assign overloaded = overload_flag_in;

   // State registers, updated once per item.
   always_ff @(posedge clock) begin
      if (reset) begin
         token_count_ff     <= cal_pkg::TOKENS_PER_PERIOD_RESET;
         token_deadline_ff  <= {{(cal_pkg::TIME_W-cal_pkg::DELAY_W){1'b0}},
                                cal_pkg::TOKEN_PERIOD_RESET};
         min_delay_ff       <= '0;
         window_deadline_ff <= {{(cal_pkg::TIME_W-cal_pkg::DELAY_W){1'b0}},
                                cal_pkg::INTERVAL_RESET};
         overload_flag_ff   <= 1'b0;
      end else if (step_en) begin
         token_count_ff     <= token_count_in;
         token_deadline_ff  <= token_deadline_in;
         min_delay_ff       <= min_delay_in;
         window_deadline_ff <= window_deadline_in;
         overload_flag_ff   <= overload_flag_in;
      end
   end

`ifndef SYNTHESIS
   // A rejected item leaves the bucket empty.
   a_reject_empty: assert property (@(posedge clock) disable iff (reset)
      step_en && !accept |=> token_count_ff == '0)
      else $error("reject left tokens in the bucket");

   // An item that closes a window is always admitted.
   a_window_accept: assert property (@(posedge clock) disable iff (reset)
      step_en && window_pass |-> accept)
      else $error("window close rejected an item");

   // Inside a window the minimum never rises.
   a_min_falls: assert property (@(posedge clock) disable iff (reset)
      step_en && !window_pass |=> min_delay_ff <= $past(min_delay_ff))
      else $error("minimum delay rose inside a window");

   // The overload flag moves only with an item.
   a_flag_hold: assert property (@(posedge clock) disable iff (reset)
      !step_en |=> $stable(overload_flag_ff))
      else $error("overload flag changed without an item");
`endif

endmodule

`default_nettype wire

// ===== design/codel_admission_limiter_core.sv =====
// Top level of the CoDel admission limiter with a token bucket.
`default_nettype none

// Each request item carries the current time and its queueing delay and gets
// one result item with an accept bit and the overload flag after the step.
// The block takes one item per clock cycle when the result side keeps up; an
// item goes from the input register through the decision logic into the result
// register. The decision uses only compares, two 48-bit deadline adds and a
// token decrement, so nothing iterates. The result register lets a new item
// enter while a finished result still waits. Registers must be written
// through the csr_ port only while the block is idle; the block does not check
// this. After reset the block is ready at once, with no clearing pass.
module codel_admission_limiter_core (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [cal_pkg::TIME_W-1:0]   req_now_us,
   input  wire logic [cal_pkg::DELAY_W-1:0]  req_queue_delay_us,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_accept,
   output logic                              rsp_overloaded,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [cal_pkg::INDEX_W-1:0]  csr_index,
   input  wire logic [cal_pkg::WDATA_W-1:0]  csr_wdata
);

   cal_pkg::cfg_type            cfg;
   logic                        in_valid_ff;
   logic [cal_pkg::TIME_W-1:0]  in_now_ff;
   logic [cal_pkg::DELAY_W-1:0] in_waiting_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_accept_ff;
   logic                        rsp_overloaded_ff;
   logic                        step_en;
   logic                        step_accept;
   logic                        step_overloaded;

   // The input item moves on when the result register is free or drains.
   assign step_en   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step_en;

   cal_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cal_step u_step (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .step_en        (step_en),
      .now_us         (in_now_ff),
      .queue_delay_us (in_waiting_ff),
      .accept         (step_accept),
      .overloaded     (step_overloaded)
   );

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_now_ff     <= req_now_us;
         in_waiting_ff <= req_queue_delay_us;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_accept_ff     <= step_accept;
         rsp_overloaded_ff <= step_overloaded;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_accept     = rsp_accept_ff;
   assign rsp_overloaded = rsp_overloaded_ff;

endmodule

`default_nettype wire

// ===== dv/codel_admission_limiter_core_test.sv =====
// Self-checking testbench for the CoDel admission limiter core.
`timescale 1ns / 100ps

module codel_admission_limiter_core_test;

   localparam int TIME_W = cal_pkg::TIME_W;
   localparam int DELAY_W = cal_pkg::DELAY_W;
   localparam int TOKEN_W = cal_pkg::TOKEN_W;
   localparam int INDEX_W = cal_pkg::INDEX_W;
   localparam int WDATA_W = cal_pkg::WDATA_W;

   // Writes to this index must be ignored by the block.
   localparam logic [INDEX_W-1:0] CSR_UNMAPPED = '1;
   localparam logic [DELAY_W-1:0] DELAY_MAX = '1;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;
   localparam int ITEMS_PER_PHASE = 155;
   localparam int RANDOM_PHASES = 7;

   typedef struct packed {
      logic accept;
      logic overloaded;
   } verdict_type;

   // Tracks the limiter state and checks each decision against it.
   class admission_scoreboard;
      logic [DELAY_W-1:0] threshold_us;
      logic [DELAY_W-1:0] discard_us;
      logic [DELAY_W-1:0] window_len_us;
      logic [TOKEN_W-1:0] refill_tokens;
      logic [DELAY_W-1:0] refill_len_us;
      logic [TOKEN_W-1:0] tokens_left;
      logic [TIME_W-1:0] refill_deadline;
      logic [TIME_W-1:0] window_end;
      logic [DELAY_W-1:0] window_min;
      logic overload;
      verdict_type decisions_due[$];
      int failures;

      function new();
         threshold_us = cal_pkg::DELAY_THRESHOLD_RESET;
         discard_us = cal_pkg::DISCARD_TIMEOUT_RESET;
         window_len_us = cal_pkg::INTERVAL_RESET;
         refill_tokens = cal_pkg::TOKENS_PER_PERIOD_RESET;
         refill_len_us = cal_pkg::TOKEN_PERIOD_RESET;
         tokens_left = cal_pkg::TOKENS_PER_PERIOD_RESET;
         refill_deadline = TIME_W'(cal_pkg::TOKEN_PERIOD_RESET);
         window_end = TIME_W'(cal_pkg::INTERVAL_RESET);
         window_min = '0;
         overload = 1'b0;
         failures = 0;
      endfunction

      function void write_register(logic [INDEX_W-1:0] index, logic [WDATA_W-1:0] data);
         case (index)
            cal_pkg::CSR_DELAY_THRESHOLD: threshold_us = data[DELAY_W-1:0];
            cal_pkg::CSR_DISCARD_TIMEOUT: discard_us = data[DELAY_W-1:0];
            cal_pkg::CSR_INTERVAL: window_len_us = data[DELAY_W-1:0];
            cal_pkg::CSR_TOKENS_PER_PERIOD: refill_tokens = data[TOKEN_W-1:0];
            cal_pkg::CSR_TOKEN_PERIOD: refill_len_us = data[DELAY_W-1:0];
            default: ;
         endcase
      endfunction

      // Advance the limiter state for one accepted request and queue its decision.
      function void note_request(logic [TIME_W-1:0] now_us, logic [DELAY_W-1:0] waited_us);
         verdict_type verdict;
         verdict.accept = 1'b1;
         if (now_us > refill_deadline) begin
            refill_deadline = refill_deadline + TIME_W'(refill_len_us);
            tokens_left = refill_tokens;
         end
         if (now_us > window_end) begin
            window_end = window_end + TIME_W'(window_len_us);
            overload = window_min > threshold_us;
            window_min = waited_us;
         end else begin
            if (waited_us < window_min) window_min = waited_us;
            if ((overload && waited_us > discard_us) || waited_us > window_len_us) begin
               if (tokens_left == '0) verdict.accept = 1'b0;
               else tokens_left = tokens_left - TOKEN_W'(1);
            end
         end
         verdict.overloaded = overload;
         decisions_due.push_back(verdict);
      endfunction

      function void check_response(logic accept, logic overloaded);
         verdict_type due;
         if (decisions_due.size() == 0) begin
            $error("result with no request outstanding: accept %0d overloaded %0d",
                   accept, overloaded);
            failures++;
            return;
         end
         due = decisions_due.pop_front();
         if (accept !== due.accept) begin
            $error("accept: expected %0d, got %0d", due.accept, accept);
            failures++;
         end
         if (overloaded !== due.overloaded) begin
            $error("overloaded: expected %0d, got %0d", due.overloaded, overloaded);
            failures++;
         end
      endfunction

      function int pending();
         return decisions_due.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [TIME_W-1:0] req_now_us;
   logic [DELAY_W-1:0] req_queue_delay_us;
   logic rsp_valid;
   logic rsp_ready;
   logic rsp_accept;
   logic rsp_overloaded;
   logic csr_valid;
   logic csr_ready;
   logic [INDEX_W-1:0] csr_index;
   logic [WDATA_W-1:0] csr_wdata;

   admission_scoreboard sb;
   int calm_req;
   int calm_rsp;

   codel_admission_limiter_core uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_now_us(req_now_us),
      .req_queue_delay_us(req_queue_delay_us),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_accept(rsp_accept),
      .rsp_overloaded(rsp_overloaded),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Gap length: mostly none or short, a few long, with calm stretches of no gaps.
   function automatic int pick_gap(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic logic [DELAY_W-1:0] clamp_delay(longint unsigned value);
      return (value > longint'(DELAY_MAX)) ? DELAY_MAX : value[DELAY_W-1:0];
   endfunction

   // Offer one request item after a random gap and record it once it is taken.
   task automatic offer_request(logic [TIME_W-1:0] now_us, logic [DELAY_W-1:0] waited_us);
      int gap;
      gap = pick_gap(calm_req);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_now_us <= now_us;
      req_queue_delay_us <= waited_us;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(now_us, waited_us);
   endtask

   // Stop offering and let every outstanding decision come back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_put(logic [INDEX_W-1:0] index, logic [WDATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_register(index, data);
   endtask

   task automatic program_limits(logic [WDATA_W-1:0] threshold, logic [WDATA_W-1:0] discard,
                                 logic [WDATA_W-1:0] interval, logic [WDATA_W-1:0] tokens,
                                 logic [WDATA_W-1:0] period);
      wait_idle();
      csr_put(cal_pkg::CSR_DELAY_THRESHOLD, threshold);
      csr_put(cal_pkg::CSR_DISCARD_TIMEOUT, discard);
      csr_put(cal_pkg::CSR_INTERVAL, interval);
      csr_put(cal_pkg::CSR_TOKENS_PER_PERIOD, tokens);
      csr_put(cal_pkg::CSR_TOKEN_PERIOD, period);
      csr_valid <= 1'b0;
   endtask

   // Random traffic: time mostly moves forward in steps below one window, with
   // alternating calm and congested stretches, deadline hits and some noise.
   task automatic run_traffic(int count);
      longint unsigned span;
      longint unsigned t_us;
      longint unsigned waited;
      logic [TIME_W-1:0] now_us;
      logic [TIME_W-1:0] base;
      bit congested;
      int r;
      int q;
      span = (sb.window_len_us == '0) ? 64 : longint'(sb.window_len_us);
      base = (sb.window_end < sb.refill_deadline) ? sb.window_end : sb.refill_deadline;
      t_us = longint'(base);
      t_us = (t_us > span) ? t_us - $urandom_range(0, 32'(span)) : 0;
      congested = 1'b0;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 11) == 0) congested = !congested;
         r = $urandom_range(0, 99);
         if (r < 3) begin
            now_us = {$urandom, $urandom};
         end else begin
            if (r < 13 && longint'(sb.window_end) >= t_us)
               t_us = longint'(sb.window_end);
            else if (r < 18 && longint'(sb.refill_deadline) >= t_us)
               t_us = longint'(sb.refill_deadline);
            else
               t_us = t_us + $urandom_range(0, 32'(span / 3));
            now_us = t_us[TIME_W-1:0];
         end
         q = $urandom_range(0, 99);
         if (q < 5)
            waited = $urandom;
         else if (q < 15)
            waited = longint'(sb.window_len_us) + $urandom_range(0, 3);
         else if (q < 25)
            waited = longint'(sb.discard_us) + $urandom_range(0, 2);
         else if (congested)
            waited = longint'(sb.threshold_us) + 1 + $urandom_range(0, 32'(span / 2));
         else
            waited = $urandom_range(0, 32'(longint'(sb.threshold_us) + span / 4));
         offer_request(now_us, clamp_delay(waited));
      end
   endtask

   // Result side: random stalls, and a checker on every accepted result.
   initial begin
      int n;
      int m;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         n = $urandom_range(1, 12);
         m = pick_gap(calm_rsp);
         rsp_ready <= 1'b1;
         repeat (n) @(posedge clock);
         if (m > 0) begin
            rsp_ready <= 1'b0;
            repeat (m) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_accept, rsp_overloaded);
   end

   initial begin
      #20000000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      int drain;
      longint unsigned interval;
      sb = new();
      calm_req = 0;
      calm_rsp = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_now_us <= '0;
      req_queue_delay_us <= '0;
      csr_valid <= 1'b0;
      csr_index <= cal_pkg::CSR_DELAY_THRESHOLD;
      csr_wdata <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset limits: first window, strict deadline compare, interval and
      // discard token use, a refill, the time extremes and time going back.
      offer_request(48'd0, 24'd0);
      offer_request(48'd2000, 24'd2001);
      offer_request(48'd2001, 24'd5000);
      offer_request(48'd3000, 24'd1200);
      offer_request(48'd4001, 24'd1100);
      offer_request(48'd4500, 24'd1600);
      offer_request(48'd4600, 24'd1500);
      offer_request(48'd1000001, 24'd0);
      offer_request(TIME_MAX, DELAY_MAX);
      offer_request(48'd0, DELAY_MAX);

      // Zero interval and period, a masked token count of one, and an unmapped write.
      program_limits(24'd0, 24'd0, 24'd0, 24'h010001, 24'd0);
      wait_idle();
      csr_put(CSR_UNMAPPED, 24'hABCDEF);
      csr_valid <= 1'b0;
      offer_request(TIME_MAX, 24'd3);
      offer_request(48'd0, 24'd5);
      offer_request(48'd0, 24'd5);
      offer_request(48'd0, 24'd0);
      offer_request(TIME_MAX, 24'd7);
      offer_request(TIME_MAX, 24'd0);
      offer_request(48'd0, 24'd9);

      // Random phases, the register extremes among them.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         interval = $urandom_range(40, 6000);
         case (phase)
            1: program_limits('1, '1, '1, '1, '1);
            2: program_limits('0, '0, '0, '0, 24'd1);
            3: program_limits(24'd1, 24'd1, 24'd1, 24'd1, 24'd3);
            default: program_limits(24'($urandom_range(0, 32'(interval))),
                                    24'($urandom_range(0, 32'(interval))),
                                    24'(interval), 24'($urandom_range(0, 8)),
                                    24'(interval * $urandom_range(2, 8)));
         endcase
         run_traffic(ITEMS_PER_PHASE);
      end

      // Drain outstanding decisions, then watch a little longer for strays.
      req_valid <= 1'b0;
      drain = 0;
      while (sb.pending() != 0 && drain < 20000) begin
         @(posedge clock);
         drain++;
      end
      repeat (8) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d decisions never arrived", sb.pending());
         sb.failures++;
      end
      if (sb.failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
